>>> rtl/sorted_max_priority_queue_assert.svh
// assertion macros for the sorted max priority queue checker
`ifndef SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SMPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/smpq_pkg.sv
package smpq_pkg;

  // queue capacity
  localparam int unsigned DEPTH = 16;
  // width of the live entry count, holds 0 .. DEPTH
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // datapath operations
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    op_e     op;
    status_e status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

>>> rtl/smpq_ctrl.sv
module smpq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [smpq_pkg::CMD_W-1:0]     command_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  smpq_pkg::dp_stat_t             stat_i,
  output smpq_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  // a new word may enter when the result register is free or drains now
  assign in_stall_o = (state_q == S_RESULT) && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_RESULT);

  // command decode into datapath operation and status
  always_comb begin
    cmd_o.load   = accept;
    cmd_o.op     = smpq_pkg::OP_NONE;
    cmd_o.status = smpq_pkg::ST_OK;
    if (command_i == smpq_pkg::CMD_INSERT) begin
      if (stat_i.full) begin
        cmd_o.status = smpq_pkg::ST_OVERFLOW;
      end else begin
        cmd_o.op = smpq_pkg::OP_INSERT;
      end
    end else if (command_i == smpq_pkg::CMD_REMOVE) begin
      if (stat_i.empty) begin
        cmd_o.status = smpq_pkg::ST_UNDERFLOW;
      end else begin
        cmd_o.op = smpq_pkg::OP_REMOVE;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_stall_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/smpq_datapath.sv
module smpq_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [smpq_pkg::DATA_W-1:0]     value_i,
  input  smpq_pkg::dp_cmd_t                      cmd_i,
  output smpq_pkg::dp_stat_t                     stat_o,
  output logic [1:0]                             status_o,
  output logic signed [smpq_pkg::DATA_W-1:0]     top_value_o,
  output logic                                   top_valid_o,
  output logic [smpq_pkg::COUNT_OUT_W-1:0]       count_o
);

  logic signed [smpq_pkg::DATA_W-1:0] entries_q [smpq_pkg::DEPTH];
  logic signed [smpq_pkg::DATA_W-1:0] entries_d [smpq_pkg::DEPTH];
  logic [smpq_pkg::CNT_W-1:0]         count_q;
  logic [smpq_pkg::CNT_W-1:0]         count_d;
  logic [smpq_pkg::DEPTH-1:0]         shift_here;

  logic [1:0]                         status_q;
  logic signed [smpq_pkg::DATA_W-1:0] top_value_q;
  logic                               top_valid_q;
  logic [smpq_pkg::COUNT_OUT_W-1:0]   count_out_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == smpq_pkg::CNT_W'(smpq_pkg::DEPTH));

  // per-slot compare: live entry not above the new value, or slot beyond the tail
  always_comb begin
    for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
      shift_here[i] = (smpq_pkg::CNT_W'(i) >= count_q) || (entries_q[i] <= value_i);
    end
  end

  // next entries: insert shifts the tail down, remove shifts all up
  always_comb begin
    for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
      entries_d[i] = entries_q[i];
    end
    count_d = count_q;
    unique case (cmd_i.op)
      smpq_pkg::OP_INSERT: begin
        for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
          if (shift_here[i]) begin
            if (i > 0 && shift_here[(i > 0) ? i - 1 : 0]) begin
              entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            end else begin
              entries_d[i] = value_i;
            end
          end
        end
        count_d = count_q + smpq_pkg::CNT_W'(1);
      end
      smpq_pkg::OP_REMOVE: begin
        for (int i = 0; i < smpq_pkg::DEPTH - 1; i++) begin
          entries_d[i] = entries_q[i + 1];
        end
        count_d = count_q - smpq_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // entry storage, no reset: only live slots are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < smpq_pkg::DEPTH; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  // live entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= cmd_i.status;
      top_valid_q <= (count_d != '0);
      top_value_q <= (count_d != '0) ? entries_d[0] : '0;
      count_out_q <= smpq_pkg::COUNT_OUT_W'(count_d);
    end
  end

  assign status_o    = status_q;
  assign top_value_o = top_value_q;
  assign top_valid_o = top_valid_q;
  assign count_o     = count_out_q;

endmodule

>>> rtl/sorted_max_priority_queue.sv
// Sorted max priority queue, up to smpq_pkg::DEPTH signed 32-bit values.
// Input channel: in_valid_i / in_stall_o carry one word of command_i and
// value_i (insert, remove largest, peek; code 3 acts as a peek).
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word: status_o, top_value_o, top_valid_o and count_o after the operation.
// A word accepted at one edge has its result valid from the next cycle on.
// Throughput is one word per cycle; the insert is a row of per-slot
// compare-and-shift cells that all update in that cycle.
// The single result register sets the rate: a new word is taken when it is
// empty or drains in the same cycle.
// While the receiver stalls, the result holds and in_stall_o stays high.
// Reset empties the queue and drops any pending result; no clearing pass
// is needed, since only live slots are ever read.
module sorted_max_priority_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [smpq_pkg::CMD_W-1:0]             command_i,
  input  logic signed [smpq_pkg::DATA_W-1:0]     value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             status_o,
  output logic signed [smpq_pkg::DATA_W-1:0]     top_value_o,
  output logic                                   top_valid_o,
  output logic [smpq_pkg::COUNT_OUT_W-1:0]       count_o
);

  smpq_pkg::dp_cmd_t  dp_cmd;
  smpq_pkg::dp_stat_t dp_stat;

  // handshake and command decode
  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // sorted storage and result word
  smpq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .top_valid_o (top_valid_o),
    .count_o     (count_o)
  );

endmodule

>>> rtl/smpq_checker.sv
`include "sorted_max_priority_queue_assert.svh"

module smpq_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic [1:0]                             status_o,
  input logic signed [smpq_pkg::DATA_W-1:0]     top_value_o,
  input logic                                   top_valid_o,
  input logic [smpq_pkg::COUNT_OUT_W-1:0]       count_o
);

  // count reported by a full queue
  localparam logic [smpq_pkg::COUNT_OUT_W-1:0] FULL_CNT =
    smpq_pkg::COUNT_OUT_W'(smpq_pkg::DEPTH);

  // a stalled result word stays offered
  `SMPQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  // valid flag agrees with the count
  `SMPQ_ASSERT_IMPL(a_top_valid, out_valid_o, top_valid_o == (count_o != '0), "top_valid")

  // empty queue reports zero as its top
  `SMPQ_ASSERT_IMPL(a_top_zero, out_valid_o && !top_valid_o, top_value_o == '0, "top not 0")

  // overflow only when full
  `SMPQ_ASSERT_IMPL(a_overflow, out_valid_o && (status_o == smpq_pkg::ST_OVERFLOW), count_o == FULL_CNT, "overflow")

  // underflow only when empty
  `SMPQ_ASSERT_IMPL(a_underflow, out_valid_o && (status_o == smpq_pkg::ST_UNDERFLOW), count_o == '0, "underflow")

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .top_value_o (top_value_o),
  .top_valid_o (top_valid_o),
  .count_o     (count_o)
);
